### hw/rtl/radio_register_access_responder_assert.svh
// assertion macros shared by the checker
`ifndef RADIO_REGISTER_ACCESS_RESPONDER_ASSERT_SVH
`define RADIO_REGISTER_ACCESS_RESPONDER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define RRAR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrar assertion failed");

// next-cycle implication, sampled on clk_i, off while in reset
`define RRAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrar assertion failed");

`endif

### hw/rtl/rrar_pkg.sv
package rrar_pkg;

  // frame and protocol constants
  localparam int unsigned FRAME_LEN     = 5;
  localparam logic [2:0]  LAST_BEAT     = 3'd4;
  localparam logic [7:0]  FN_WRITE      = 8'h10;
  localparam logic [7:0]  FN_READ       = 8'h03;
  localparam logic [7:0]  BC_SYNC       = 8'hBB;
  localparam logic [7:0]  BC_ID         = 8'hFF;
  localparam logic [7:0]  NODE_ADDR_REG = 8'd19;
  localparam logic [7:0]  RSSI_REG      = 8'd31;
  localparam logic [15:0] NODE_ADDR_RST = 16'd254;
  localparam logic [7:0]  THR_RST       = 8'd30;
  localparam logic [7:0]  BCAST_RST     = 8'hFF;

  // input item modes and result kinds
  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_POLL  = 1'b1;
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_SYNC  = 1'b1;

  typedef enum logic [0:0] {
    CFG_RSSI_THR   = 1'b0,
    CFG_BCAST_ADDR = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
    logic       last_byte;
    logic [7:0] rssi;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] reply_byte;
    logic       last_of_reply;
  } result_t;

  typedef struct packed {
    logic [7:0] rssi_thr;
    logic [7:0] bcast_addr;
  } cfg_t;

  // one queued command: a finished packet or a poll
  typedef struct packed {
    logic                          is_poll;
    logic [7:0]                    rssi;
    logic [FRAME_LEN-1:0][7:0]     pkt;
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // back end states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_SEND = 3'b100
  } back_state_e;

  // value of a holding register that was never written
  function automatic logic [15:0] reg_rst_val(input logic [7:0] r);
    return (r == NODE_ADDR_REG) ? NODE_ADDR_RST : 16'd0;
  endfunction

endpackage

### hw/rtl/rrar_front.sv
module rrar_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  rrar_pkg::item_t  item_i,
  output logic             push_o,
  output rrar_pkg::cmd_t   cmd_o
);

  logic [rrar_pkg::FRAME_LEN-1:0][7:0] pkt_q, pkt_d;
  logic [2:0]                          idx_q, idx_d;

  // collect packet bytes, close a packet on its last byte
  always_comb begin
    pkt_d = pkt_q;
    idx_d = idx_q;
    if (accept_i && (item_i.mode == rrar_pkg::MODE_BYTE)) begin
      if (idx_q < 3'(rrar_pkg::FRAME_LEN)) begin
        pkt_d[idx_q] = item_i.rx_byte;
        idx_d        = idx_q + 3'd1;
      end
      if (item_i.last_byte) begin
        idx_d = 3'd0;
      end
    end
  end

  // a poll or a packet end becomes one queued command
  assign push_o        = accept_i &&
                         ((item_i.mode == rrar_pkg::MODE_POLL) || item_i.last_byte);
  assign cmd_o.is_poll = (item_i.mode == rrar_pkg::MODE_POLL);
  assign cmd_o.rssi    = item_i.rssi;
  assign cmd_o.pkt     = pkt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
      idx_q <= 3'd0;
    end else begin
      pkt_q <= pkt_d;
      idx_q <= idx_d;
    end
  end

endmodule

### hw/rtl/rrar_queue.sv
module rrar_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rrar_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output rrar_pkg::cmd_t    cmd_o,
  output rrar_pkg::q_stat_t stat_o
);

  rrar_pkg::cmd_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = ent_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### hw/rtl/rrar_back.sv
module rrar_back #(
  parameter int unsigned REG_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrar_pkg::cfg_t    cfg_i,
  input  rrar_pkg::cmd_t    cmd_i,
  input  rrar_pkg::q_stat_t stat_i,
  output logic              pop_o,
  output logic              result_valid_o,
  output rrar_pkg::result_t result_o
);

  localparam int unsigned IDX_W   = $clog2(REG_COUNT);
  localparam logic [8:0]  REG_LIM = 9'(REG_COUNT);

  rrar_pkg::back_state_e               state_q, state_d;
  logic [rrar_pkg::FRAME_LEN-1:0][7:0] frame_q, frame_d;
  logic                                pend_q, pend_d;
  logic [2:0]                          cnt_q, cnt_d;
  logic [15:0]                         node_q, node_d;
  logic                                res_vld_q, res_vld_d;
  rrar_pkg::result_t                   res_q, res_d;

  logic [15:0]      mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;
  logic             we;
  logic [IDX_W-1:0] widx;
  logic [15:0]      wdata;
  logic [15:0]      rd_data_q;
  logic             rd_vld_q, rd_rng_q;
  logic [7:0]       rreg_q;
  logic [15:0]      rd_val;

  logic [7:0]       addr_b, fn_b, reg_b;
  logic             reg_rng, node_hit;
  logic [IDX_W-1:0] ridx;

  assign addr_b   = cmd_i.pkt[0];
  assign fn_b     = cmd_i.pkt[1];
  assign reg_b    = cmd_i.pkt[2];
  assign reg_rng  = ({1'b0, reg_b} < REG_LIM);
  assign ridx     = reg_b[IDX_W-1:0];
  assign node_hit = ({8'h00, addr_b} == node_q);

  // value of a register read, taking unwritten entries at their reset value
  assign rd_val = !rd_rng_q ? 16'd0 :
                  rd_vld_q  ? rd_data_q : rrar_pkg::reg_rst_val(rreg_q);

  // command execution
  always_comb begin
    state_d   = state_q;
    frame_d   = frame_q;
    pend_d    = pend_q;
    cnt_d     = cnt_q;
    node_d    = node_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    pop_o     = 1'b0;
    we        = 1'b0;
    widx      = ridx;
    wdata     = {cmd_i.pkt[3], cmd_i.pkt[4]};
    case (state_q)
      rrar_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (cmd_i.is_poll) begin
            // poll: store rssi, release a pending reply on a quiet channel
            we    = 1'b1;
            widx  = IDX_W'(rrar_pkg::RSSI_REG);
            wdata = {8'h00, cmd_i.rssi};
            if (pend_q && (cmd_i.rssi < cfg_i.rssi_thr)) begin
              pend_d  = 1'b0;
              cnt_d   = 3'd0;
              state_d = rrar_pkg::ST_SEND;
            end
          end else if (node_hit) begin
            if (fn_b == rrar_pkg::FN_WRITE) begin
              we = reg_rng;
              if (reg_rng && (reg_b == rrar_pkg::NODE_ADDR_REG)) begin
                node_d = wdata;
              end
              frame_d[0] = (reg_rng && (reg_b == rrar_pkg::NODE_ADDR_REG)) ?
                           cmd_i.pkt[4] : node_q[7:0];
              frame_d[1] = rrar_pkg::FN_WRITE;
              frame_d[2] = reg_b;
              frame_d[3] = 8'd0;
              frame_d[4] = 8'd1;
              pend_d     = 1'b1;
            end else if (fn_b == rrar_pkg::FN_READ) begin
              state_d = rrar_pkg::ST_RD;
            end
          end else if (addr_b == cfg_i.bcast_addr) begin
            if (fn_b == rrar_pkg::BC_SYNC) begin
              res_vld_d           = 1'b1;
              res_d.kind          = rrar_pkg::KIND_SYNC;
              res_d.reply_byte    = 8'd0;
              res_d.last_of_reply = 1'b1;
            end else if (fn_b == rrar_pkg::BC_ID) begin
              frame_d[0] = node_q[7:0];
              frame_d[1] = 8'd0;
              frame_d[2] = 8'd0;
              frame_d[3] = 8'd0;
              frame_d[4] = 8'd0;
              pend_d     = 1'b1;
            end
          end
        end
      end
      rrar_pkg::ST_RD: begin
        // read data from the registered read port arrives in the cycle after the address
        frame_d[0] = node_q[7:0];
        frame_d[1] = rrar_pkg::FN_READ;
        frame_d[2] = rreg_q;
        frame_d[3] = rd_val[15:8];
        frame_d[4] = rd_val[7:0];
        pend_d     = 1'b1;
        state_d    = rrar_pkg::ST_IDLE;
      end
      rrar_pkg::ST_SEND: begin
        // one reply beat per cycle
        res_vld_d           = 1'b1;
        res_d.kind          = rrar_pkg::KIND_REPLY;
        res_d.reply_byte    = frame_q[cnt_q];
        res_d.last_of_reply = (cnt_q == rrar_pkg::LAST_BEAT);
        cnt_d               = cnt_q + 3'd1;
        if (cnt_q == rrar_pkg::LAST_BEAT) begin
          state_d = rrar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rrar_pkg::ST_IDLE;
      end
    endcase
  end

  // holding register file with registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[widx] <= wdata;
    end
    rd_data_q <= mem_q[ridx];
    rd_vld_q  <= vld_q[ridx];
    rd_rng_q  <= reg_rng;
    rreg_q    <= reg_b;
  end

  // written flags per register entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[widx] <= 1'b1;
    end
  end

  // control and reply state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrar_pkg::ST_IDLE;
      frame_q   <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= 3'd0;
      node_q    <= rrar_pkg::NODE_ADDR_RST;
      res_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      frame_q   <= frame_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      node_q    <= node_d;
      res_vld_q <= res_vld_d;
      res_q     <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

### hw/rtl/radio_register_access_responder.sv
// Radio register-access responder. Items (packet bytes or RSSI polls) are taken with
// start_i while busy_o is low; busy_o rises only when the two-entry command queue is
// full. Packet bytes that do not end a packet are absorbed in the same cycle. Each
// queued command is decoded by the back end in ST_IDLE, a register read also passes
// through ST_RD (the holding register memory has a registered read port), and a poll
// that releases the pending reply moves on to ST_SEND for five reply beats, one per
// cycle. Results appear on result_o for a single cycle with result_valid_o high and
// cannot be stalled; the five beats of a reply always come in consecutive cycles.
module radio_register_access_responder #(
  parameter int unsigned REG_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rrar_pkg::item_t   item_i,
  output logic              result_valid_o,
  output rrar_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i
);

  rrar_pkg::cfg_t    cfg_q;
  rrar_pkg::cmd_t    push_cmd, head_cmd;
  rrar_pkg::q_stat_t q_stat;
  logic              accept, push, pop;

  assign busy_o = q_stat.full;
  assign accept = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rssi_thr   <= rrar_pkg::THR_RST;
      cfg_q.bcast_addr <= rrar_pkg::BCAST_RST;
    end else if (cfg_we_i) begin
      case (rrar_pkg::cfg_idx_e'(cfg_idx_i))
        rrar_pkg::CFG_RSSI_THR:   cfg_q.rssi_thr   <= cfg_wdata_i;
        rrar_pkg::CFG_BCAST_ADDR: cfg_q.bcast_addr <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  rrar_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  rrar_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  rrar_back #(
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (head_cmd),
    .stat_i         (q_stat),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### hw/rtl/rrar_checker.sv
`include "radio_register_access_responder_assert.svh"

module rrar_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              result_valid_o,
  input rrar_pkg::result_t result_o
);

  // a sync pulse is a lone beat with a zero byte
  `RRAR_ASSERT_NOW(a_sync_shape, result_valid_o && (result_o.kind == rrar_pkg::KIND_SYNC), result_o.last_of_reply && (result_o.reply_byte == 8'd0))

  // reply beats run back to back until the last one
  `RRAR_ASSERT_NEXT(a_reply_burst, result_valid_o && (result_o.kind == rrar_pkg::KIND_REPLY) && !result_o.last_of_reply, result_valid_o && (result_o.kind == rrar_pkg::KIND_REPLY))

  // the closing reply beat follows an open reply beat
  `RRAR_ASSERT_NOW(a_reply_close, result_valid_o && (result_o.kind == rrar_pkg::KIND_REPLY) && result_o.last_of_reply, $past(result_valid_o && (result_o.kind == rrar_pkg::KIND_REPLY) && !result_o.last_of_reply))

endmodule

bind radio_register_access_responder rrar_checker u_rrar_checker (.*);

### verif/tb_radio_register_access_responder.sv
module tb_radio_register_access_responder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 56;

  // expected behavior of the responder plus the queue of beats it still owes
  class responder_model;
    logic [15:0]       hold_regs [256];
    logic [7:0]        pkt_buf [rrar_pkg::FRAME_LEN];
    int unsigned       pkt_fill;
    logic [7:0]        reply_buf [rrar_pkg::FRAME_LEN];
    bit                reply_armed;
    logic [7:0]        rssi_thr;
    logic [7:0]        bcast_addr;
    rrar_pkg::result_t beats_due [$];
    int unsigned       errors;

    function new();
      foreach (hold_regs[i]) hold_regs[i] = 16'h0000;
      hold_regs[rrar_pkg::NODE_ADDR_REG] = rrar_pkg::NODE_ADDR_RST;
      foreach (pkt_buf[i]) pkt_buf[i] = 8'h00;
      foreach (reply_buf[i]) reply_buf[i] = 8'h00;
      pkt_fill    = 0;
      reply_armed = 1'b0;
      rssi_thr    = rrar_pkg::THR_RST;
      bcast_addr  = rrar_pkg::BCAST_RST;
      errors      = 0;
    endfunction

    function void set_cfg(rrar_pkg::cfg_idx_e idx, logic [7:0] val);
      case (idx)
        rrar_pkg::CFG_RSSI_THR:   rssi_thr = val;
        rrar_pkg::CFG_BCAST_ADDR: bcast_addr = val;
        default: ;
      endcase
    endfunction

    // the address byte is taken from register 19 after any write
    function void arm_reply(logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
      reply_buf[0] = hold_regs[rrar_pkg::NODE_ADDR_REG][7:0];
      reply_buf[1] = b1;
      reply_buf[2] = b2;
      reply_buf[3] = b3;
      reply_buf[4] = b4;
      reply_armed  = 1'b1;
    endfunction

    // command check at the end of a packet
    function void decode_packet();
      logic [15:0] val;
      if ({8'h00, pkt_buf[0]} == hold_regs[rrar_pkg::NODE_ADDR_REG]) begin
        if (pkt_buf[1] == rrar_pkg::FN_WRITE) begin
          hold_regs[pkt_buf[2]] = {pkt_buf[3], pkt_buf[4]};
          arm_reply(rrar_pkg::FN_WRITE, pkt_buf[2], 8'h00, 8'h01);
        end else if (pkt_buf[1] == rrar_pkg::FN_READ) begin
          val = hold_regs[pkt_buf[2]];
          arm_reply(rrar_pkg::FN_READ, pkt_buf[2], val[15:8], val[7:0]);
        end
      end else if (pkt_buf[0] == bcast_addr) begin
        if (pkt_buf[1] == rrar_pkg::BC_SYNC) begin
          beats_due.push_back('{kind: rrar_pkg::KIND_SYNC, reply_byte: 8'h00,
                                last_of_reply: 1'b1});
        end else if (pkt_buf[1] == rrar_pkg::BC_ID) begin
          arm_reply(8'h00, 8'h00, 8'h00, 8'h00);
        end
      end
    endfunction

    function void absorb_item(rrar_pkg::item_t it);
      if (it.mode == rrar_pkg::MODE_BYTE) begin
        if (pkt_fill < rrar_pkg::FRAME_LEN) begin
          pkt_buf[pkt_fill] = it.rx_byte;
          pkt_fill++;
        end
        if (it.last_byte) begin
          decode_packet();
          pkt_fill = 0;
        end
      end else begin
        hold_regs[rrar_pkg::RSSI_REG] = {8'h00, it.rssi};
        if (reply_armed && (it.rssi < rssi_thr)) begin
          for (int k = 0; k < rrar_pkg::FRAME_LEN; k++) begin
            beats_due.push_back('{kind: rrar_pkg::KIND_REPLY, reply_byte: reply_buf[k],
                                  last_of_reply: (k == rrar_pkg::FRAME_LEN - 1)});
          end
          reply_armed = 1'b0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task compare_beat(rrar_pkg::result_t got);
      rrar_pkg::result_t want;
      if (beats_due.size() == 0) begin
        report($sformatf("beat with nothing owed: kind %0b byte %02h last %0b",
                         got.kind, got.reply_byte, got.last_of_reply));
        return;
      end
      want = beats_due.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0b, want %0b", got.kind, want.kind));
      if (got.reply_byte !== want.reply_byte)
        report($sformatf("reply_byte %02h, want %02h", got.reply_byte, want.reply_byte));
      if (got.last_of_reply !== want.last_of_reply)
        report($sformatf("last_of_reply %0b, want %0b", got.last_of_reply, want.last_of_reply));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  rrar_pkg::item_t   item_i;
  logic              result_valid_o;
  rrar_pkg::result_t result_o;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [7:0]        cfg_wdata_i;

  responder_model model = new();
  int unsigned    idle_cycles;
  int unsigned    items_sent;
  int unsigned    gap_mode;
  logic [7:0]     cur_addr;
  logic [7:0]     frame_q [$];

  radio_register_access_responder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // monitor: beats out, items in, activity for the watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (result_valid_o) model.compare_beat(result_o);
      if (start_i && !busy_o) model.absorb_item(item_i);
      if (result_valid_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // one input beat, held until the block takes it
  task automatic send_item(input rrar_pkg::item_t it);
    int unsigned gap;
    case (gap_mode)
      0: gap = 0;
      1: gap = $urandom_range(0, 11);
      default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    endcase
    @(negedge clk_i);
    repeat (gap) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic rrar_pkg::item_t byte_item(logic [7:0] b, logic last);
    return '{mode: rrar_pkg::MODE_BYTE, rx_byte: b, last_byte: last, rssi: 8'($urandom)};
  endfunction

  function automatic rrar_pkg::item_t poll_item(logic [7:0] rssi);
    return '{mode: rrar_pkg::MODE_POLL, rx_byte: 8'($urandom), last_byte: 1'($urandom),
             rssi: rssi};
  endfunction

  // send frame_q as one packet, last marker on its final byte
  task automatic send_frame();
    foreach (frame_q[i]) send_item(byte_item(frame_q[i], i == frame_q.size() - 1));
  endtask

  // stop sending and wait until every owed beat has come
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (model.beats_due.size() != 0) @(posedge clk_i);
  endtask

  // register writes only while the block is idle
  task automatic write_cfg(rrar_pkg::cfg_idx_e idx, logic [7:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'($urandom);
    model.set_cfg(idx, val);
  endtask

  function automatic logic [7:0] pick_reg();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) return 8'($urandom_range(0, 7));
    if (sel < 11) return rrar_pkg::RSSI_REG;
    if (sel == 11) return rrar_pkg::NODE_ADDR_REG;
    return 8'($urandom);
  endfunction

  // mostly well-formed commands and polls, some broadcasts and noise
  task automatic random_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned extra;
    logic [7:0]  r;
    logic [15:0] v;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) gap_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 39) == 0) drain();
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        // register write, sometimes too long
        r = pick_reg();
        v = 16'($urandom);
        if (r == rrar_pkg::NODE_ADDR_REG) v[15:8] = 8'h00;
        frame_q = {cur_addr, rrar_pkg::FN_WRITE, r, v[15:8], v[7:0]};
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        repeat (extra) frame_q.push_back(8'($urandom));
        send_frame();
        if (r == rrar_pkg::NODE_ADDR_REG) cur_addr = v[7:0];
      end else if (sel < 40) begin
        // register read, three to five bytes
        frame_q = {cur_addr, rrar_pkg::FN_READ, pick_reg()};
        extra = $urandom_range(0, 2);
        repeat (extra) frame_q.push_back(8'($urandom));
        send_frame();
      end else if (sel < 50) begin
        // broadcast
        case ($urandom_range(0, 2))
          0: frame_q = {model.bcast_addr, rrar_pkg::BC_SYNC};
          1: frame_q = {model.bcast_addr, rrar_pkg::BC_ID};
          default: frame_q = {model.bcast_addr, 8'($urandom)};
        endcase
        extra = $urandom_range(0, 3);
        repeat (extra) frame_q.push_back(8'($urandom));
        send_frame();
      end else if (sel < 80) begin
        // poll, often below the threshold
        if ($urandom_range(0, 1) == 0)
          send_item(poll_item(8'($urandom_range(0, model.rssi_thr))));
        else
          send_item(poll_item(8'($urandom)));
      end else if (sel < 90) begin
        // noise packet
        frame_q = {};
        extra = $urandom_range(1, 7);
        repeat (extra) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 2) == 0) frame_q[0] = cur_addr;
        send_frame();
      end else begin
        send_item(rrar_pkg::item_t'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = rrar_pkg::CFG_RSSI_THR;
    cfg_wdata_i = 8'h00;
    items_sent  = 0;
    gap_mode    = 2;
    cur_addr    = rrar_pkg::NODE_ADDR_RST[7:0];
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: poll with nothing pending
    send_item(poll_item(8'h00));
    // write, poll at the threshold holds it, poll below sends it
    frame_q = {cur_addr, rrar_pkg::FN_WRITE, 8'h05, 8'hA5, 8'h5A};
    send_frame();
    send_item(poll_item(rrar_pkg::THR_RST));
    send_item(poll_item(rrar_pkg::THR_RST - 8'd1));
    // short read reuses the old trailing bytes
    frame_q = {cur_addr, rrar_pkg::FN_READ, 8'h05};
    send_frame();
    send_item(poll_item(8'h00));
    // sync pulse and id reply, then a read that replaces the id reply
    frame_q = {rrar_pkg::BCAST_RST, rrar_pkg::BC_SYNC};
    send_frame();
    frame_q = {rrar_pkg::BCAST_RST, rrar_pkg::BC_ID};
    send_frame();
    frame_q = {cur_addr, rrar_pkg::FN_READ, 8'hFF};
    send_frame();
    send_item(poll_item(8'h00));
    // unknown function, then a too long write
    frame_q = {cur_addr, 8'h55};
    send_frame();
    send_item(poll_item(8'h00));
    frame_q = {cur_addr, rrar_pkg::FN_WRITE, 8'h07, 8'h12, 8'h34, 8'h99, 8'h88};
    send_frame();
    // rssi lands in register 31 and reads back
    send_item(poll_item(8'hFF));
    frame_q = {cur_addr, rrar_pkg::FN_READ, rrar_pkg::RSSI_REG};
    send_frame();
    send_item(poll_item(8'h00));
    send_item(byte_item(8'h00, 1'b1));
    drain();

    // random phases over several register settings
    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'h00);
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, 8'h00);
    random_traffic(PHASE_ITEMS);

    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'hFF);
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, cur_addr);
    random_traffic(PHASE_ITEMS);

    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'($urandom));
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, 8'($urandom));
    random_traffic(PHASE_ITEMS);

    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'h80);
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, 8'hFF);
    random_traffic(PHASE_ITEMS);

    write_cfg(rrar_pkg::CFG_RSSI_THR, rrar_pkg::THR_RST);
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, 8'($urandom));
    random_traffic(PHASE_ITEMS);

    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'($urandom_range(100, 255)));
    write_cfg(rrar_pkg::CFG_BCAST_ADDR, rrar_pkg::BCAST_RST);
    random_traffic(PHASE_ITEMS);

    // node address above one byte: no packet addresses the node any more
    write_cfg(rrar_pkg::CFG_RSSI_THR, 8'hC8);
    frame_q = {cur_addr, rrar_pkg::FN_WRITE, rrar_pkg::NODE_ADDR_REG, 8'h01, 8'h00};
    send_frame();
    send_item(poll_item(8'h00));
    frame_q = {8'h00, rrar_pkg::FN_READ, 8'h05};
    send_frame();
    send_item(poll_item(8'h00));
    frame_q = {rrar_pkg::BCAST_RST, rrar_pkg::BC_ID};
    send_frame();
    send_item(poll_item(8'hC7));

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (model.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/rrar_pkg.sv
hw/rtl/rrar_front.sv
hw/rtl/rrar_queue.sv
hw/rtl/rrar_back.sv
hw/rtl/radio_register_access_responder.sv
hw/rtl/rrar_checker.sv
verif/tb_radio_register_access_responder.sv
